// ===== rtl/core/rnb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnb_pkg
// Shared constants for the RMS norm backward block.
// ----------------------------------------------------------------------------
package rnb_pkg;
  localparam int unsigned IdxRowWidth = 0;
  localparam int unsigned IdxEpsilon  = 1;
  localparam logic [63:0] Cap62 = 64'h4000_0000_0000_0000;
  localparam logic signed [39:0] GsMax = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] GsMin = -40'sh80_0000_0000;
endpackage

// ===== rtl/core/rnb_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnb_mul
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module rnb_mul
  import rnb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  logic [2:0]   step_r, step_nxt;
  logic         busy_r, busy_nxt;
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;

  always_comb begin
    pa = step_r[1] ? a_r[63:32] : a_r[31:0];
    pb = step_r[0] ? b_r[63:32] : b_r[31:0];
  end
  assign pp = {32'd0, pa} * {32'd0, pb};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + ({64'd0, pp} << (7'd32 * ({6'd0, step_r[1]} + {6'd0, step_r[0]})));
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
  end

  assign done = busy_r && step_r == 3'd3;
  assign prod = acc_nxt;
endmodule

// ===== rtl/core/rnb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnb_div
// Restoring divider and integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module rnb_div
  import rnb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sqrt_mode,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic [6:0]  cnt_r;
  logic [63:0] n_r, d_r, q_r;
  logic [64:0] rem_r;
  logic [64:0] trial;
  logic [65:0] rtrial;
  logic [65:0] rshift;

  assign trial  = {rem_r[63:0], n_r[63]} - {1'b0, d_r};
  assign rshift = {rem_r[63:0], n_r[63:62]};
  assign rtrial = rshift - {q_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= sqrt_mode ? 7'd32 : 7'd64;
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      // done rises together with the final quotient bit in the quotient register.
      done_r <= cnt_r == 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
    end
    if (start) begin
      mode_r <= sqrt_mode;
      n_r    <= num;
      d_r    <= den;
      q_r    <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (mode_r) begin
        n_r <= {n_r[61:0], 2'b00};
        if (!rtrial[65]) begin
          rem_r <= rtrial[64:0];
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rshift[64:0];
          q_r   <= {q_r[62:0], 1'b0};
        end
      end else begin
        n_r <= {n_r[62:0], 1'b0};
        if (!trial[64]) begin
          rem_r <= {1'b0, trial[63:0]};
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[63:0], n_r[63]};
          q_r   <= {q_r[62:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// ===== rtl/core/rms_norm_backward_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_norm_backward_top
// Backward pass of RMS normalization with a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Usage: each in_ item carries one column element of a row (activation,
// grad_out, scale_weight). in_tready is high while the row is filling; one
// item is stored per cycle. The item that completes the row starts the
// compute: a sweep over the row for sum of squares and the dot product,
// a 64-step divide for the mean, a 64-step divide and a 32-step root for the
// reciprocal root, two products for the cube of the root, a 64-step divide
// by the width, a product for the correction, then per column three
// products on the shared multiplier. in_tready stays low until the last
// result of the row is in the output register. Results leave on out_ with
// tlast on the final column. When out_tready is low the sequencer waits
// with the next result until the output register is free. Reset clears
// the fill count and the scale-gradient valid bits and sets the registers
// to row_width 64 and epsilon 17.
// ----------------------------------------------------------------------------
module rms_norm_backward_top
  import rnb_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // activation[15:0], grad_out[31:16], scale_weight[47:32]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // column[5:0], x_grad[37:6], grad_scale_total[77:38], pad
  output logic [79:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  localparam logic [4:0] S_FILL = 5'd0,  S_SQ = 5'd1,  S_SQW = 5'd2,
                         S_DSW = 5'd3,   S_DSWW = 5'd4, S_MEAN = 5'd5,
                         S_MEANW = 5'd6, S_RDIV = 5'd7, S_RDIVW = 5'd8,
                         S_ROOT = 5'd9,  S_ROOTW = 5'd10, S_K2 = 5'd11,
                         S_K2W = 5'd12, S_K3 = 5'd13, S_K3W = 5'd14,
                         S_KW = 5'd15,  S_KWW = 5'd16, S_CORR = 5'd17,
                         S_CORRW = 5'd18, S_RD = 5'd19, S_P1 = 5'd20,
                         S_P1W = 5'd21, S_P2 = 5'd22, S_P2W = 5'd23,
                         S_P3 = 5'd24, S_P3W = 5'd25, S_OUT = 5'd26,
                         S_EMIT = 5'd27;

  logic [4:0]  state_r;
  logic [6:0]  width_cfg_r;
  logic [15:0] eps_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] w_r;
  logic [AW-1:0] col_r;
  logic [47:0] row_mem [MAX_WIDTH];
  logic [39:0] sg_mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] sg_vld_r;
  logic [47:0] rd_r;
  logic [39:0] sg_rd_r;
  logic [63:0] sq_r, inv_r, k2_r, kw_r, corr_r;
  logic signed [63:0] dot_r;
  logic signed [31:0] gs_r, gx_r;
  logic [63:0] m1_r, m2_r;
  logic [79:0] out_data_r;
  logic        out_last_r;
  logic [CW-1:0] weff;
  logic        mstart, mdone, dstart, dsqrt, ddone;
  logic [63:0] ma, mb, dnum, dden, dquo;
  logic [127:0] mprod;
  logic signed [15:0] xv, gv, sv;
  logic [63:0] v_w;

  assign xv = rd_r[15:0];
  assign gv = rd_r[31:16];
  assign sv = rd_r[47:32];

  always_comb begin
    if (width_cfg_r == 7'd0) weff = CW'(1);
    else if ({25'd0, width_cfg_r} > MAX_WIDTH) weff = CW'(MAX_WIDTH);
    else weff = CW'(width_cfg_r);
  end

  function automatic logic [63:0] shr_cap(input logic [127:0] p, input int sh);
    logic [127:0] s;
    s = p >> sh;
    if (s[127:63] != '0 || s[62:0] > Cap62[62:0]) return Cap62;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : v;
  endfunction

  rnb_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone),
                 .prod(mprod));
  rnb_div u_div (.clk, .rst_n, .start(dstart), .sqrt_mode(dsqrt), .num(dnum),
                 .den(dden), .done(ddone), .quo(dquo));

  assign v_w = (sq_r + {48'd0, eps_r} == 64'd0) ? 64'd1 : sq_r + {48'd0, eps_r};

  always_comb begin
    mstart = 1'b0; ma = '0; mb = '0;
    dstart = 1'b0; dsqrt = 1'b0; dnum = '0; dden = {{(64-CW){1'b0}}, w_r};
    case (state_r)
      S_SQ: begin
        mstart = 1'b1;
        ma = mag64(64'(xv));
        mb = mag64(64'(xv));
      end
      S_DSW: begin
        mstart = 1'b1;
        ma = mag64(64'(32'(gv) * 32'(sv)));
        mb = mag64(64'(xv));
      end
      S_MEAN: begin dstart = 1'b1; dnum = sq_r; end
      S_RDIV: begin dstart = 1'b1; dnum = 64'h0100_0000_0000_0000; dden = v_w; end
      S_ROOT: begin dstart = 1'b1; dsqrt = 1'b1; dnum = dquo; end
      S_K2: begin mstart = 1'b1; ma = inv_r; mb = inv_r; end
      S_K3: begin mstart = 1'b1; ma = k2_r; mb = inv_r; end
      S_KW: begin dstart = 1'b1; dnum = k2_r; end
      S_CORR: begin mstart = 1'b1; ma = mag64(dot_r); mb = kw_r; end
      S_P1: begin mstart = 1'b1; ma = mag64(64'(32'(gv) * 32'(sv))); mb = inv_r; end
      S_P2: begin mstart = 1'b1; ma = mag64(64'(xv)); mb = corr_r; end
      S_P3: begin mstart = 1'b1; ma = mag64(64'(gx_r)); mb = inv_r; end
      default: ;
    endcase
  end

  logic signed [64:0] gi_w, tot_w;
  logic signed [39:0] sg_old;
  logic signed [63:0] t1, t2, st;
  always_comb begin
    t1 = gs_r[31] ? -$signed(m1_r) : $signed(m1_r);
    t2 = (xv[15] != dot_r[63]) ? -$signed(m2_r) : $signed(m2_r);
    gi_w = 65'(t1) - 65'(t2);
    st = gx_r[31] ? -$signed(shr_cap(mprod, 24)) : $signed(shr_cap(mprod, 24));
    sg_old = sg_vld_r[col_r] ? sg_rd_r : 40'sd0;
    tot_w = 65'(sg_old) + 65'(st);
  end

  logic [31:0] gi_sat;
  logic [39:0] tot_sat;
  always_comb begin
    if (gi_w > 65'sd2147483647) gi_sat = 32'h7FFF_FFFF;
    else if (gi_w < -65'sd2147483648) gi_sat = 32'h8000_0000;
    else gi_sat = gi_w[31:0];
    if (tot_w > 65'(GsMax)) tot_sat = GsMax;
    else if (tot_w < 65'(GsMin)) tot_sat = GsMin;
    else tot_sat = tot_w[39:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      width_cfg_r <= 7'd64;
      eps_r <= 16'd17;
      fill_r <= '0;
      sg_vld_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'(IdxRowWidth)) width_cfg_r <= cfg_data[6:0];
        else width_cfg_r <= width_cfg_r;
        if (cfg_index == 1'(IdxEpsilon)) eps_r <= cfg_data;
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (state_r)
        S_FILL: if (in_tvalid) begin
          if (fill_r + CW'(1) >= weff) begin
            fill_r <= '0; w_r <= weff; col_r <= '0;
            sq_r <= '0; dot_r <= '0; state_r <= S_RD;
          end else fill_r <= fill_r + CW'(1);
        end
        S_RD: state_r <= (sq_r == 64'hFFFF_FFFF_FFFF_FFFF) ? S_P1 : S_SQ;
        S_SQ: state_r <= S_SQW;
        S_SQW: if (mdone) begin sq_r <= sq_r + mprod[63:0]; state_r <= S_DSW; end
        S_DSW: state_r <= S_DSWW;
        S_DSWW: if (mdone) begin
          dot_r <= (gv[15] ^ sv[15] ^ xv[15]) && (xv != 0) && (gv != 0) && (sv != 0)
                 ? dot_r - $signed(mprod[63:0]) : dot_r + $signed(mprod[63:0]);
          if ({1'b0, col_r} == (CW)'(w_r - CW'(1))) begin
            col_r <= '0; state_r <= S_MEAN;
          end else begin col_r <= col_r + AW'(1); state_r <= S_RD; end
        end
        S_MEAN: state_r <= S_MEANW;
        S_MEANW: if (ddone) begin sq_r <= dquo; state_r <= S_RDIV; end
        S_RDIV: state_r <= S_RDIVW;
        S_RDIVW: if (ddone) state_r <= S_ROOT;
        S_ROOT: state_r <= S_ROOTW;
        S_ROOTW: if (ddone) begin inv_r <= dquo; state_r <= S_K2; end
        S_K2: state_r <= S_K2W;
        S_K2W: if (mdone) begin k2_r <= shr_cap(mprod, 16); state_r <= S_K3; end
        S_K3: state_r <= S_K3W;
        S_K3W: if (mdone) begin k2_r <= shr_cap(mprod, 16); state_r <= S_KW; end
        S_KW: state_r <= S_KWW;
        S_KWW: if (ddone) begin kw_r <= dquo; state_r <= S_CORR; end
        S_CORR: state_r <= S_CORRW;
        S_CORRW: if (mdone) begin
          corr_r <= shr_cap(mprod, 36);
          sq_r <= 64'hFFFF_FFFF_FFFF_FFFF;
          state_r <= S_RD;
        end
        S_P1: begin
          gs_r <= 32'(gv) * 32'(sv);
          gx_r <= 32'(gv) * 32'(xv);
          state_r <= S_P1W;
        end
        S_P1W: if (mdone) begin m1_r <= shr_cap(mprod, 24); state_r <= S_P2; end
        S_P2: state_r <= S_P2W;
        S_P2W: if (mdone) begin m2_r <= shr_cap(mprod, 12); state_r <= S_P3; end
        S_P3: state_r <= S_P3W;
        S_P3W: if (mdone) state_r <= S_EMIT;
        // The multiplier keeps its product, so the result can wait here.
        S_EMIT: if (!out_tvalid) begin
          sg_vld_r[col_r] <= 1'b1;
          out_data_r <= {2'b00, tot_sat, gi_sat, 6'(col_r)};
          out_last_r <= {1'b0, col_r} == (CW)'(w_r - CW'(1));
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if ({1'b0, col_r} == (CW)'(w_r - CW'(1))) state_r <= S_FILL;
               else begin col_r <= col_r + AW'(1); state_r <= S_RD; end
        default: state_r <= S_FILL;
      endcase
    end
  end

  // hold_r registers the S_P3W state and keeps cfg_ready low while it is set.
  logic hold_r;
  always_ff @(posedge clk) begin
    if (state_r == S_FILL && in_tvalid && fill_r < CW'(MAX_WIDTH))
      row_mem[fill_r[AW-1:0]] <= in_tdata;
    rd_r <= row_mem[col_r];
    sg_rd_r <= sg_mem[col_r];
    if (state_r == S_EMIT && !out_tvalid) sg_mem[col_r] <= tot_sat;
    hold_r <= state_r == S_P3W;
  end

  assign in_tready  = state_r == S_FILL;
  assign cfg_ready  = state_r == S_FILL && !hold_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_WIDTH)) else $error("fill count out of range");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_FILL |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("held result changed");
endmodule
